// ===== rtl/mbtrp_pkg.sv =====
// Modbus TCP request parser package: result record, push control and frame constants.
// Used by every module of the parser; depends on nothing.

package mbtrp_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 511;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam int POS_TID_HI  = 0;
	localparam int POS_TID_LO  = 1;
	localparam int POS_PROT_HI = 2;
	localparam int POS_PROT_LO = 3;
	localparam int POS_LEN_HI  = 4;
	localparam int POS_LEN_LO  = 5;
	localparam int POS_UNIT    = 6;
	localparam int POS_FC      = 7;
	localparam int POS_ADDR_HI = 8;
	localparam int POS_ADDR_LO = 9;
	localparam int POS_QTY_HI  = 10;
	localparam int POS_QTY_LO  = 11;
	localparam int POS_COUNT   = 12;
	localparam int POS_DATA    = 13;
	localparam int HDR_END     = 8;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic        frame_valid;
		logic [15:0] txn_id;
		logic [15:0] header_length;
		logic [7:0]  unit_id;
		logic [7:0]  func_code;
		logic [15:0] start_address;
		logic [15:0] qty_value;
		logic [7:0]  data_byte_count;
		logic [3:0]  present_flags;
	} result_t;

	typedef struct packed {
		logic push_first;
		logic push_second;
	} push_t;

endpackage

// ===== rtl/mbtrp_parse.sv =====
// Parser stage: input register, header and field registers, result formation.
// Depends on mbtrp_pkg; feeds mbtrp_queue with up to two results per byte.

module mbtrp_parse #(
	parameter int MAX_FRAME_BYTES = mbtrp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          frame_byte,
	input  logic                is_last,
	input  logic                room,
	output mbtrp_pkg::push_t    push,
	output mbtrp_pkg::result_t  res_first,
	output mbtrp_pkg::result_t  res_second
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      tid_q, prot_q, len_q, addr_q, qty_q;
	logic [7:0]       unit_q, fc_q, cnt_q;

	logic [15:0]      tid_n, prot_n, len_n, addr_n, qty_n;
	logic [7:0]       unit_n, fc_n, cnt_n;
	logic [POS_W-1:0] pos_n, pdiff;
	logic [POS_W:0]   data_end;
	logic             take, proc, accept, multi, multi_n, pay, hdr_ok;
	mbtrp_pkg::result_t pay_res, sum_res;

	assign proc       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= frame_byte;
			last_s1 <= is_last;
		end
	end

	assign take  = pos_q < POS_W'(MAX_FRAME_BYTES);
	assign multi = (fc_q == mbtrp_pkg::FC_WR_COILS) || (fc_q == mbtrp_pkg::FC_WR_REGS);

	always_comb begin
		tid_n  = tid_q;
		prot_n = prot_q;
		len_n  = len_q;
		unit_n = unit_q;
		fc_n   = fc_q;
		addr_n = addr_q;
		qty_n  = qty_q;
		cnt_n  = cnt_q;
		if (take) begin
			case (pos_q)
				POS_W'(mbtrp_pkg::POS_TID_HI):  tid_n[15:8]  = byte_s1;
				POS_W'(mbtrp_pkg::POS_TID_LO):  tid_n[7:0]   = byte_s1;
				POS_W'(mbtrp_pkg::POS_PROT_HI): prot_n[15:8] = byte_s1;
				POS_W'(mbtrp_pkg::POS_PROT_LO): prot_n[7:0]  = byte_s1;
				POS_W'(mbtrp_pkg::POS_LEN_HI):  len_n[15:8]  = byte_s1;
				POS_W'(mbtrp_pkg::POS_LEN_LO):  len_n[7:0]   = byte_s1;
				POS_W'(mbtrp_pkg::POS_UNIT):    unit_n       = byte_s1;
				POS_W'(mbtrp_pkg::POS_FC):      fc_n         = byte_s1;
				POS_W'(mbtrp_pkg::POS_ADDR_HI): addr_n[15:8] = byte_s1;
				POS_W'(mbtrp_pkg::POS_ADDR_LO): addr_n[7:0]  = byte_s1;
				POS_W'(mbtrp_pkg::POS_QTY_HI):  qty_n[15:8]  = byte_s1;
				POS_W'(mbtrp_pkg::POS_QTY_LO):  qty_n[7:0]   = byte_s1;
				POS_W'(mbtrp_pkg::POS_COUNT): begin
					if (multi) begin
						cnt_n = byte_s1;
					end
				end
				default: ;
			endcase
		end
	end

	assign pos_n    = take ? pos_q + POS_W'(1) : pos_q;
	assign pdiff    = pos_q - POS_W'(mbtrp_pkg::POS_DATA);
	assign pay      = take && (pos_q >= POS_W'(mbtrp_pkg::POS_DATA)) && multi &&
		(prot_q == 16'd0) && (pdiff < {{(POS_W-8){1'b0}}, cnt_q});
	assign multi_n  = (fc_n == mbtrp_pkg::FC_WR_COILS) || (fc_n == mbtrp_pkg::FC_WR_REGS);
	assign hdr_ok   = (pos_n >= POS_W'(mbtrp_pkg::HDR_END)) && (prot_n == 16'd0);
	assign data_end = (POS_W+1)'(mbtrp_pkg::POS_DATA) + {{(POS_W-7){1'b0}}, cnt_n};

	always_comb begin
		pay_res               = '0;
		pay_res.item_kind     = mbtrp_pkg::KIND_PAYLOAD;
		pay_res.payload_byte  = byte_s1;
		pay_res.payload_index = pdiff[7:0];

		sum_res           = '0;
		sum_res.item_kind = mbtrp_pkg::KIND_SUMMARY;
		if (hdr_ok) begin
			sum_res.frame_valid    = 1'b1;
			sum_res.txn_id         = tid_n;
			sum_res.header_length  = len_n;
			sum_res.unit_id        = unit_n;
			sum_res.func_code      = fc_n;
			if (pos_n >= POS_W'(mbtrp_pkg::POS_QTY_HI)) begin
				sum_res.start_address    = addr_n;
				sum_res.present_flags[0] = 1'b1;
			end
			if (pos_n >= POS_W'(mbtrp_pkg::POS_COUNT)) begin
				sum_res.qty_value        = qty_n;
				sum_res.present_flags[1] = 1'b1;
			end
			if (multi_n && (pos_n >= POS_W'(mbtrp_pkg::POS_DATA))) begin
				sum_res.data_byte_count  = cnt_n;
				sum_res.present_flags[2] = 1'b1;
				sum_res.present_flags[3] = {1'b0, pos_n} >= data_end;
			end
		end
	end

	assign res_first        = pay ? pay_res : sum_res;
	assign res_second       = sum_res;
	assign push.push_first  = proc && (pay || last_s1);
	assign push.push_second = proc && pay && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tid_q  <= '0;
			prot_q <= '0;
			len_q  <= '0;
			unit_q <= '0;
			fc_q   <= '0;
			addr_q <= '0;
			qty_q  <= '0;
			cnt_q  <= '0;
		end else if (proc) begin
			if (last_s1) begin
				pos_q  <= '0;
				tid_q  <= '0;
				prot_q <= '0;
				len_q  <= '0;
				unit_q <= '0;
				fc_q   <= '0;
				addr_q <= '0;
				qty_q  <= '0;
				cnt_q  <= '0;
			end else begin
				pos_q  <= pos_n;
				tid_q  <= tid_n;
				prot_q <= prot_n;
				len_q  <= len_n;
				unit_q <= unit_n;
				fc_q   <= fc_n;
				addr_q <= addr_n;
				qty_q  <= qty_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

// ===== rtl/mbtrp_queue.sv =====
// Result queue: small register FIFO taking up to two results per cycle, one out.
// Depends on mbtrp_pkg for the result record and push control.

module mbtrp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mbtrp_pkg::push_t    push,
	input  mbtrp_pkg::result_t  res_first,
	input  mbtrp_pkg::result_t  res_second,
	output logic                room,
	output logic                item_valid,
	input  logic                item_stall,
	output mbtrp_pkg::result_t  head
);

	localparam int DEPTH = mbtrp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	mbtrp_pkg::result_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q, n_push;
	logic             pop;

	assign item_valid = count_q != '0;
	assign pop        = item_valid && !item_stall;
	assign room       = count_q <= (PTR_W+1)'(DEPTH - 2);
	assign head       = entry_q[rd_q];
	assign n_push     = (PTR_W+1)'(push.push_first) + (PTR_W+1)'(push.push_second);

	always_ff @(posedge clk) begin
		if (push.push_first) begin
			entry_q[wr_q] <= res_first;
		end
		if (push.push_second) begin
			entry_q[wr_q + PTR_W'(1)] <= res_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[PTR_W-1:0];
			count_q <= count_q + n_push - (PTR_W+1)'(pop);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
		end
	end

endmodule

// ===== rtl/modbus_tcp_request_parser_unit.sv =====
// Modbus TCP request parser top level: joins the parser stage and the result queue.
// Depends on mbtrp_pkg, mbtrp_parse and mbtrp_queue.
//
// Input channel: one frame byte per transaction (frame_byte, is_last), with
// byte_valid and byte_stall. Output channel: one result per transaction,
// item_kind 0 for a data byte of a write-multiple request, 1 for the frame
// summary that closes each frame, with item_valid and item_stall.
// A byte taken is held in the input register and its results are then written
// into the result queue. Throughput: one byte per cycle while the queue has room;
// a last byte that also carries a data byte yields two results, which leave
// through the single output port of the four-entry result queue one at a time;
// the input register holds a byte until the queue has room for two results.
// When the receiver stalls the queue fills and byte_stall rises once three or
// more results are queued. Reset clears the position counter, all header
// registers and the queue; the first byte after reset starts a new frame.

module modbus_tcp_request_parser_unit #(
	parameter int MAX_FRAME_BYTES = mbtrp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  frame_byte,
	input  logic        is_last,
	output logic        item_valid,
	input  logic        item_stall,
	output logic        item_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic        frame_valid,
	output logic [15:0] txn_id,
	output logic [15:0] header_length,
	output logic [7:0]  unit_id,
	output logic [7:0]  func_code,
	output logic [15:0] start_address,
	output logic [15:0] qty_value,
	output logic [7:0]  data_byte_count,
	output logic [3:0]  present_flags
);

	mbtrp_pkg::push_t   push;
	mbtrp_pkg::result_t res_first, res_second, head;
	logic               room;

	mbtrp_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.frame_byte (frame_byte),
		.is_last    (is_last),
		.room       (room),
		.push       (push),
		.res_first  (res_first),
		.res_second (res_second)
	);

	mbtrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.res_first  (res_first),
		.res_second (res_second),
		.room       (room),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.head       (head)
	);

	assign item_kind         = head.item_kind;
	assign payload_byte      = head.payload_byte;
	assign payload_index     = head.payload_index;
	assign frame_valid       = head.frame_valid;
	assign txn_id            = head.txn_id;
	assign header_length     = head.header_length;
	assign unit_id           = head.unit_id;
	assign func_code         = head.func_code;
	assign start_address     = head.start_address;
	assign qty_value         = head.qty_value;
	assign data_byte_count   = head.data_byte_count;
	assign present_flags     = head.present_flags;

endmodule

// ===== rtl/mbtrp_checker.sv =====
// Port-level checker for the Modbus TCP request parser, bound to the top level.
// Depends on mbtrp_pkg for the result kind codes.

module mbtrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        item_kind,
	input logic [7:0]  payload_byte,
	input logic [7:0]  payload_index,
	input logic        frame_valid,
	input logic [15:0] txn_id,
	input logic [15:0] header_length,
	input logic [7:0]  unit_id,
	input logic [7:0]  func_code,
	input logic [15:0] start_address,
	input logic [15:0] qty_value,
	input logic [7:0]  data_byte_count,
	input logic [3:0]  present_flags
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid)
		else $error("result withdrawn while stalled");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_kind == mbtrp_pkg::KIND_PAYLOAD |->
		!frame_valid && present_flags == 4'd0 && data_byte_count == 8'd0 &&
		txn_id == 16'd0)
		else $error("data item carries summary fields");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_kind == mbtrp_pkg::KIND_SUMMARY |->
		payload_byte == 8'd0 && payload_index == 8'd0)
		else $error("summary carries data byte fields");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_kind == mbtrp_pkg::KIND_SUMMARY && !frame_valid |->
		txn_id == 16'd0 && header_length == 16'd0 && unit_id == 8'd0 &&
		func_code == 8'd0 && start_address == 16'd0 &&
		qty_value == 16'd0 && present_flags == 4'd0)
		else $error("invalid frame summary not cleared");

	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |->
		(!present_flags[3] || present_flags[2]) &&
		(!present_flags[2] || present_flags[1]) &&
		(!present_flags[1] || present_flags[0]))
		else $error("presence flags out of order");

endmodule

bind modbus_tcp_request_parser_unit mbtrp_checker u_mbtrp_checker (.*);

// ===== tb/sv/tb_modbus_tcp_request_parser_unit.sv =====
// Testbench for modbus_tcp_request_parser_unit: directed frames, then random request frames.
// Every result is checked against a local frame parser model; depends on mbtrp_pkg.

module tb_modbus_tcp_request_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1650;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int HOLD_OFF_AT  = 1500;

	localparam mbtrp_pkg::result_t REJECTED_SUMMARY =
		'{item_kind: mbtrp_pkg::KIND_SUMMARY, default: '0};

	localparam logic [7:0] WR_REGS_FRAME [14] = '{
		8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08, 8'hFF,
		mbtrp_pkg::FC_WR_REGS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA5
	};

	typedef struct {
		logic [7:0]         b;
		logic               last;
		bit                 typed;
		mbtrp_pkg::result_t want;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  frame_byte = 8'h00;
	logic        is_last = 1'b0;
	logic        item_valid;
	logic        item_stall = 1'b0;
	logic        item_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic        frame_valid;
	logic [15:0] txn_id;
	logic [15:0] header_length;
	logic [7:0]  unit_id;
	logic [7:0]  func_code;
	logic [15:0] start_address;
	logic [15:0] qty_value;
	logic [7:0]  data_byte_count;
	logic [3:0]  present_flags;

	frame_row_t         byte_rows[$];
	mbtrp_pkg::result_t parsed_due[$];
	int         errors = 0;
	int         cycle_count = 0;

	int          frame_pos;
	logic [15:0] mbap_tid;
	logic [15:0] mbap_proto;
	logic [15:0] mbap_len;
	logic [7:0]  mbap_unit;
	logic [7:0]  req_fc;
	logic [15:0] req_addr;
	logic [15:0] req_qty;
	logic [7:0]  req_count;

	modbus_tcp_request_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.frame_byte(frame_byte),
		.is_last(is_last),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_kind(item_kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_valid(frame_valid),
		.txn_id(txn_id),
		.header_length(header_length),
		.unit_id(unit_id),
		.func_code(func_code),
		.start_address(start_address),
		.qty_value(qty_value),
		.data_byte_count(data_byte_count),
		.present_flags(present_flags)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_frame();
		frame_pos  = 0;
		mbap_tid   = '0;
		mbap_proto = '0;
		mbap_len   = '0;
		mbap_unit  = '0;
		req_fc     = '0;
		req_addr   = '0;
		req_qty    = '0;
		req_count  = '0;
	endfunction

	function automatic void parse_frame_byte(logic [7:0] b, logic last);
		mbtrp_pkg::result_t r;
		logic    multi;
		case (frame_pos)
			mbtrp_pkg::POS_TID_HI:  mbap_tid[15:8] = b;
			mbtrp_pkg::POS_TID_LO:  mbap_tid[7:0] = b;
			mbtrp_pkg::POS_PROT_HI: mbap_proto[15:8] = b;
			mbtrp_pkg::POS_PROT_LO: mbap_proto[7:0] = b;
			mbtrp_pkg::POS_LEN_HI:  mbap_len[15:8] = b;
			mbtrp_pkg::POS_LEN_LO:  mbap_len[7:0] = b;
			mbtrp_pkg::POS_UNIT:    mbap_unit = b;
			mbtrp_pkg::POS_FC:      req_fc = b;
			mbtrp_pkg::POS_ADDR_HI: req_addr[15:8] = b;
			mbtrp_pkg::POS_ADDR_LO: req_addr[7:0] = b;
			mbtrp_pkg::POS_QTY_HI:  req_qty[15:8] = b;
			mbtrp_pkg::POS_QTY_LO:  req_qty[7:0] = b;
			mbtrp_pkg::POS_COUNT: begin
				if (req_fc == mbtrp_pkg::FC_WR_COILS || req_fc == mbtrp_pkg::FC_WR_REGS)
					req_count = b;
			end
			default: ;
		endcase
		multi = (req_fc == mbtrp_pkg::FC_WR_COILS || req_fc == mbtrp_pkg::FC_WR_REGS);
		if (frame_pos < mbtrp_pkg::MAX_FRAME_BYTES_DEF) begin
			if (frame_pos >= mbtrp_pkg::POS_DATA && multi && mbap_proto == '0 &&
					frame_pos - mbtrp_pkg::POS_DATA < req_count) begin
				r = '0;
				r.item_kind = mbtrp_pkg::KIND_PAYLOAD;
				r.payload_byte = b;
				r.payload_index = 8'(frame_pos - mbtrp_pkg::POS_DATA);
				parsed_due = {parsed_due, r};
			end
			frame_pos++;
		end
		if (last) begin
			r = '0;
			r.item_kind = mbtrp_pkg::KIND_SUMMARY;
			if (frame_pos >= mbtrp_pkg::HDR_END && mbap_proto == '0) begin
				r.frame_valid = 1'b1;
				r.txn_id = mbap_tid;
				r.header_length = mbap_len;
				r.unit_id = mbap_unit;
				r.func_code = req_fc;
				if (frame_pos > mbtrp_pkg::POS_ADDR_LO) begin
					r.start_address = req_addr;
					r.present_flags[0] = 1'b1;
				end
				if (frame_pos > mbtrp_pkg::POS_QTY_LO) begin
					r.qty_value = req_qty;
					r.present_flags[1] = 1'b1;
				end
				if (multi && frame_pos > mbtrp_pkg::POS_COUNT) begin
					r.data_byte_count = req_count;
					r.present_flags[2] = 1'b1;
					r.present_flags[3] = (frame_pos >= mbtrp_pkg::POS_DATA + req_count);
				end
			end
			parsed_due = {parsed_due, r};
			clear_frame();
		end
	endfunction

	function automatic void add_byte(logic [7:0] b, logic last, bit typed = 1'b0,
			mbtrp_pkg::result_t want = '0);
		frame_row_t row;
		row.b = b;
		row.last = last;
		row.typed = typed;
		row.want = want;
		byte_rows = {byte_rows, row};
	endfunction

	function automatic void add_random_frame(bit overlong);
		logic [7:0]  hdr [13];
		int unsigned sel;
		int unsigned len;
		int unsigned cnt;
		logic [7:0]  fc;
		sel = $urandom_range(0, 99);
		cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
		if ($urandom_range(0, 4) == 0)
			fc = 8'($urandom);
		else
			fc = $urandom_range(0, 1) ? mbtrp_pkg::FC_WR_COILS : mbtrp_pkg::FC_WR_REGS;
		foreach (hdr[i]) hdr[i] = 8'($urandom);
		hdr[mbtrp_pkg::POS_PROT_HI] = 8'h00;
		hdr[mbtrp_pkg::POS_PROT_LO] = 8'h00;
		hdr[mbtrp_pkg::POS_FC] = fc;
		hdr[mbtrp_pkg::POS_COUNT] = 8'(cnt);
		if (fc == mbtrp_pkg::FC_WR_COILS || fc == mbtrp_pkg::FC_WR_REGS)
			len = mbtrp_pkg::POS_DATA + cnt;
		else
			len = $urandom_range(mbtrp_pkg::HDR_END, mbtrp_pkg::POS_DATA);
		if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 4);
		if (overlong) begin
			hdr[mbtrp_pkg::POS_FC] = mbtrp_pkg::FC_WR_REGS;
			hdr[mbtrp_pkg::POS_COUNT] = 8'hFF;
			len = $urandom_range(mbtrp_pkg::MAX_FRAME_BYTES_DEF + 4,
				mbtrp_pkg::MAX_FRAME_BYTES_DEF + 20);
		end else if (sel >= 92) begin
			foreach (hdr[i]) hdr[i] = 8'($urandom);
			len = $urandom_range(1, 20);
		end else if (sel >= 80) begin
			{hdr[mbtrp_pkg::POS_PROT_HI], hdr[mbtrp_pkg::POS_PROT_LO]} =
				16'($urandom_range(1, 65535));
		end else if (sel >= 65) begin
			len = $urandom_range(1, len);
		end
		for (int i = 0; i < len; i++)
			add_byte(i < 13 ? hdr[i] : 8'($urandom), i == len - 1);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	initial begin : sender
		int unsigned burst_left;
		int unsigned gap;
		frame_row_t  row;
		clear_frame();
		add_byte(8'hFF, 1'b1, 1'b1, REJECTED_SUMMARY);
		repeat (7) add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b1, REJECTED_SUMMARY);
		for (int i = 0; i < 14; i++) add_byte(WR_REGS_FRAME[i], i == 13);
		add_random_frame(1'b1);
		while (byte_rows.size() < RANDOM_BYTES + 23) add_random_frame(1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = 0;
		foreach (byte_rows[i]) begin
			row = byte_rows[i];
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					byte_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			byte_valid <= 1'b1;
			frame_byte <= row.b;
			is_last <= row.last;
			do @(posedge clk); while (byte_stall);
			parse_frame_byte(row.b, row.last);
			if (row.typed) parsed_due[parsed_due.size() - 1] = row.want;
		end
		byte_valid <= 1'b0;
		while (parsed_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb_modbus_tcp_request_parser_unit: clean");
		else
			$display("tb_modbus_tcp_request_parser_unit: errors");
		$finish;
	end

	initial begin : receiver
		int unsigned rx_cycle;
		int unsigned hold_left;
		bit          s;
		rx_cycle = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_left == 0 && (rx_cycle == HOLD_OFF_AT || $urandom_range(0, 1999) == 0))
				hold_left = $urandom_range(150, 300);
			if (hold_left != 0) begin
				hold_left--;
				s = 1'b1;
			end else begin
				case ((rx_cycle / 150) % 4)
					0: s = 1'b0;
					1: s = ($urandom_range(0, 3) == 0);
					2: s = ($urandom_range(0, 3) != 0);
					default: s = (rx_cycle % 7) < 3;
				endcase
			end
			item_stall <= s;
		end
	end

	always @(posedge clk) begin
		mbtrp_pkg::result_t seen;
		mbtrp_pkg::result_t want;
		if (arst_n && item_valid && !item_stall) begin
			seen = {item_kind, payload_byte, payload_index, frame_valid, txn_id,
				header_length, unit_id, func_code, start_address, qty_value,
				data_byte_count, present_flags};
			if (parsed_due.size() == 0) begin
				$error("result transaction with none expected: kind %0b", seen.item_kind);
				errors++;
			end else begin
				want = parsed_due.pop_front();
				check_field("item_kind", want.item_kind, seen.item_kind);
				check_field("payload_byte", want.payload_byte, seen.payload_byte);
				check_field("payload_index", want.payload_index, seen.payload_index);
				check_field("frame_valid", want.frame_valid, seen.frame_valid);
				check_field("txn_id", want.txn_id, seen.txn_id);
				check_field("header_length", want.header_length, seen.header_length);
				check_field("unit_id", want.unit_id, seen.unit_id);
				check_field("func_code", want.func_code, seen.func_code);
				check_field("start_address", want.start_address, seen.start_address);
				check_field("qty_value", want.qty_value, seen.qty_value);
				check_field("data_byte_count", want.data_byte_count, seen.data_byte_count);
				check_field("present_flags", want.present_flags, seen.present_flags);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_modbus_tcp_request_parser_unit: errors");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/mbtrp_pkg.sv
rtl/mbtrp_parse.sv
rtl/mbtrp_queue.sv
rtl/modbus_tcp_request_parser_unit.sv
rtl/mbtrp_checker.sv
tb/sv/tb_modbus_tcp_request_parser_unit.sv
